### hw/rtl/hna_pkg.sv
// Shared types and constants of the held-note arpeggiator.
package hna_pkg;

   localparam int MAX_NOTES_DEF = 16;
   localparam int NOTE_W        = 7;
   localparam int STEP_W        = 24;
   localparam int PCT_W         = 7;
   localparam int PROD_W        = STEP_W + PCT_W;
   localparam int DIV_W         = 32;
   localparam int DVS_W         = 7;

   localparam logic [STEP_W-1:0] STEP_TICKS_RST = 24'd125;
   localparam logic [PCT_W-1:0]  GATE_PCT_RST   = 7'd60;
   localparam logic [PCT_W-1:0]  GATE_PCT_MIN   = 7'd10;
   localparam logic [PCT_W-1:0]  GATE_PCT_MAX   = 7'd100;
   localparam logic [31:0]       RANDOM_RST     = 32'd1;

   // One hundredth scaled by 2**38 and rounded up; exact for every step and percent product.
   localparam int          RECIP_SH  = 38;
   localparam logic [31:0] PCT_RECIP = 32'd2748779070;

   localparam logic [1:0] REG_ARP_MODE   = 2'd0;
   localparam logic [1:0] REG_STEP_TICKS = 2'd1;
   localparam logic [1:0] REG_GATE_PCT   = 2'd2;

   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_UP     = 2'd1;
   localparam logic [1:0] MODE_DOWN   = 2'd2;
   localparam logic [1:0] MODE_RANDOM = 2'd3;

   typedef enum logic [1:0] {
      OP_HOLD    = 2'd0,
      OP_RELEASE = 2'd1,
      OP_TICK    = 2'd2,
      OP_ALL_OFF = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      EV_ON  = 2'd0,
      EV_OFF = 2'd1,
      EV_ALL = 2'd2
   } event_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_STEP,
      ST_DIVPOS,
      ST_PICK,
      ST_GSTART,
      ST_DIVGATE,
      ST_ON,
      ST_ALLOFF
   } state_type;

   typedef struct packed {
      logic wr;
      logic shift;
      logic load;
      logic rot;
      logic live;
   } cell_ctl_type;

endpackage

### hw/rtl/hna_cell.sv
// One cell of the held-note row: a note, a rotating compare token and its rank.
module hna_cell #(
   parameter int IDX_W = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hna_pkg::cell_ctl_type        ctl,
   input  logic [hna_pkg::NOTE_W-1:0]   wr_note,
   input  logic [hna_pkg::NOTE_W-1:0]   next_note,
   input  logic [hna_pkg::NOTE_W-1:0]   query,
   input  logic [hna_pkg::NOTE_W-1:0]   pass_in,
   input  logic                         pass_vld_in,
   output logic [hna_pkg::NOTE_W-1:0]   note_q,
   output logic [hna_pkg::NOTE_W-1:0]   pass_q,
   output logic                         pass_vld_q,
   output logic [IDX_W-1:0]             rank_q,
   output logic                         hit
);

   logic [hna_pkg::NOTE_W-1:0] note_ff, note_in;
   logic [hna_pkg::NOTE_W-1:0] pass_ff, pass_in_nx;
   logic                       pass_vld_ff, pass_vld_in_nx;
   logic [IDX_W-1:0]           rank_ff, rank_in;

   always_comb begin
      note_in        = note_ff;
      pass_in_nx     = pass_ff;
      pass_vld_in_nx = pass_vld_ff;
      rank_in        = rank_ff;
      if (ctl.wr) begin
         note_in = wr_note;
      end else if (ctl.shift) begin
         note_in = next_note;
      end
      if (ctl.load) begin
         pass_in_nx     = note_ff;
         pass_vld_in_nx = ctl.live;
         rank_in        = '0;
      end else if (ctl.rot) begin
         // Count every live note that passes by and is lower than our own.
         pass_in_nx     = pass_in;
         pass_vld_in_nx = pass_vld_in;
         if (pass_vld_ff && (pass_ff < note_ff)) begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_vld_ff <= 1'b0;
      end else begin
         pass_vld_ff <= pass_vld_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      note_ff <= note_in;
      pass_ff <= pass_in_nx;
      rank_ff <= rank_in;
   end

   assign note_q     = note_ff;
   assign pass_q     = pass_ff;
   assign pass_vld_q = pass_vld_ff;
   assign rank_q     = rank_ff;
   assign hit        = (note_ff == query);

endmodule

### hw/rtl/hna_div.sv
// Bit-serial restoring divider giving the remainder, one bit a cycle.
module hna_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [hna_pkg::DIV_W-1:0]   dividend,
   input  logic [hna_pkg::DVS_W-1:0]   divisor,
   output logic                        done,
   output logic [hna_pkg::DVS_W-1:0]   rem
);

   localparam int CNT_W = $clog2(hna_pkg::DIV_W + 1);

   logic [hna_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [hna_pkg::DVS_W-1:0] rem_ff, rem_in;
   logic [hna_pkg::DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      done_ff, done_in;
   logic [hna_pkg::DVS_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[hna_pkg::DIV_W-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(hna_pkg::DIV_W);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = hna_pkg::DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[hna_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[hna_pkg::DVS_W-1:0];
            quo_in = {quo_ff[hna_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

### hw/rtl/held_note_arpeggiator_top.sv
// Held-note arpeggiator: a row of note cells, a serial divider and a step sequencer.
// The block takes one request beat at a time. Hold, release and tick beats that cause
// no arpeggiator step pass through the execute state, waiting for the result channel
// if it is stalled. A beat that takes a step (sort, pick, gate length) runs a 32-bit
// bit-serial remainder for the note position while the notes rotate once round the
// cell row to find each note's rank, then picks the note, forms the gate length by
// reciprocal multiplication, and may wait for the result channel. An all-off beat sends
// an off result for each sounding note, then an all-notes-off result. A result beat
// waits in the output register while the next request is accepted.
module held_note_arpeggiator_top #(
   parameter int MAX_NOTES = hna_pkg::MAX_NOTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] note, [7] zero
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] note_out, [7] zero
   output logic [1:0]  rsp_tuser,   // [1:0] event_res
   output logic        rsp_tlast,
   // Register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CNT_W = $clog2(MAX_NOTES + 1);
   localparam int IDX_W = $clog2(MAX_NOTES);
   localparam int POS_W = IDX_W + 1;
   localparam int NW    = hna_pkg::NOTE_W;
   localparam int SW    = hna_pkg::STEP_W;
   localparam int PW    = hna_pkg::PCT_W;

   hna_pkg::state_type state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [NW-1:0]      qnote_ff, qnote_in;
   logic [1:0]         mode_ff;
   logic [SW-1:0]      step_ticks_ff;
   logic [PW-1:0]      gate_pct_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [NW-1:0]      snd_note_ff, snd_note_in;
   logic               snd_vld_ff, snd_vld_in;
   logic [SW-1:0]      step_cnt_ff, step_cnt_in;
   logic [SW-1:0]      gate_cnt_ff, gate_cnt_in;
   logic               running_ff, running_in;
   logic [31:0]        rnd_ff, rnd_in;
   logic [CNT_W-1:0]   rot_cnt_ff, rot_cnt_in;
   logic [hna_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [SW-1:0]      gate_q_ff, gate_q_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_ev_ff, rsp_ev_in;
   logic [NW-1:0]      rsp_note_ff, rsp_note_in;
   logic               rsp_last_ff, rsp_last_in;

   hna_pkg::cell_ctl_type ctl [MAX_NOTES];
   logic [NW-1:0]      cell_note [MAX_NOTES];
   logic [NW-1:0]      cell_pass [MAX_NOTES];
   logic               cell_pvld [MAX_NOTES];
   logic [IDX_W-1:0]   cell_rank [MAX_NOTES];
   logic               cell_hit  [MAX_NOTES];

   logic               div_start, div_done;
   logic [31:0]        div_dividend;
   logic [hna_pkg::DVS_W-1:0] div_divisor, div_rem;

   logic               emit, emit_last, out_free, found, csr_wr;
   logic [1:0]         emit_ev;
   logic [NW-1:0]      emit_note, sel_note;
   logic [MAX_NOTES-1:0] shift_vec;
   logic [SW-1:0]      st_eff, gate_len;
   logic [PW-1:0]      gp_eff;
   logic [63:0]        gate_mul;
   logic [31:0]        x1, x2, x3;
   logic [POS_W-1:0]   pos_up, pos_dn;
   logic               fire, goff, more_on, run_acc;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= hna_pkg::MODE_OFF;
         step_ticks_ff <= hna_pkg::STEP_TICKS_RST;
         gate_pct_ff   <= hna_pkg::GATE_PCT_RST;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            hna_pkg::REG_ARP_MODE:   mode_ff       <= csr_pwdata[1:0];
            hna_pkg::REG_STEP_TICKS: step_ticks_ff <= csr_pwdata[SW-1:0];
            hna_pkg::REG_GATE_PCT:   gate_pct_ff   <= csr_pwdata[PW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         hna_pkg::REG_ARP_MODE:   csr_prdata = {30'd0, mode_ff};
         hna_pkg::REG_STEP_TICKS: csr_prdata = {8'd0, step_ticks_ff};
         hna_pkg::REG_GATE_PCT:   csr_prdata = {25'd0, gate_pct_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // Cell row
   for (genvar i = 0; i < MAX_NOTES; i++) begin : g_cell
      localparam int NXT = (i + 1) % MAX_NOTES;
      hna_cell #(.IDX_W(IDX_W)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl[i]),
         .wr_note     (qnote_ff),
         .next_note   (cell_note[NXT]),
         .query       (qnote_ff),
         .pass_in     (cell_pass[NXT]),
         .pass_vld_in (cell_pvld[NXT]),
         .note_q      (cell_note[i]),
         .pass_q      (cell_pass[i]),
         .pass_vld_q  (cell_pvld[i]),
         .rank_q      (cell_rank[i]),
         .hit         (cell_hit[i])
      );
   end

   hna_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .rem      (div_rem)
   );

   // Lookup over the live cells: match for hold and release, rank select for a step.
   always_comb begin
      run_acc  = 1'b0;
      found    = 1'b0;
      sel_note = '0;
      for (int i = 0; i < MAX_NOTES; i++) begin
         if ((CNT_W'(i) < count_ff) && cell_hit[i]) begin
            run_acc = 1'b1;
            found   = 1'b1;
         end
         shift_vec[i] = run_acc;
         if ((CNT_W'(i) < count_ff) && (cell_rank[i] == pos_ff[IDX_W-1:0])) begin
            sel_note = sel_note | cell_note[i];
         end
      end
   end

   always_comb begin
      x1 = rnd_ff ^ (rnd_ff << 13);
      x2 = x1 ^ (x1 >> 17);
      x3 = x2 ^ (x2 << 5);
   end

   assign st_eff   = (step_ticks_ff == '0) ? SW'(1) : step_ticks_ff;
   assign gp_eff   = (gate_pct_ff < hna_pkg::GATE_PCT_MIN) ? hna_pkg::GATE_PCT_MIN :
                     (gate_pct_ff > hna_pkg::GATE_PCT_MAX) ? hna_pkg::GATE_PCT_MAX : gate_pct_ff;
   assign gate_mul = 64'(prod_ff) * 64'(hna_pkg::PCT_RECIP);
   assign gate_len = (gate_q_ff == '0) ? SW'(1) : gate_q_ff;
   assign pos_up   = pos_ff + 1'b1;
   assign pos_dn   = pos_ff - 1'b1;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign more_on  = (mode_ff != hna_pkg::MODE_OFF) && (count_ff != '0);
   assign fire     = (step_cnt_ff <= SW'(1));
   assign goff     = (gate_cnt_ff == SW'(1)) && snd_vld_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      qnote_in     = qnote_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      snd_note_in  = snd_note_ff;
      snd_vld_in   = snd_vld_ff;
      step_cnt_in  = step_cnt_ff;
      gate_cnt_in  = gate_cnt_ff;
      running_in   = running_ff;
      rnd_in       = rnd_ff;
      rot_cnt_in   = rot_cnt_ff;
      prod_in      = prod_ff;
      gate_q_in    = gate_q_ff;
      req_tready   = 1'b0;
      emit         = 1'b0;
      emit_ev      = hna_pkg::EV_ON;
      emit_note    = '0;
      emit_last    = 1'b1;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = hna_pkg::DVS_W'(count_ff);
      for (int i = 0; i < MAX_NOTES; i++) begin
         ctl[i]      = '0;
         ctl[i].live = (CNT_W'(i) < count_ff);
      end

      case (state_ff)
         hna_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in    = req_tuser;
               qnote_in = req_tdata[NW-1:0];
               state_in = hna_pkg::ST_EXEC;
            end
         end

         hna_pkg::ST_EXEC: begin
            case (op_ff)
               hna_pkg::OP_HOLD: begin
                  if (!(found || count_ff == CNT_W'(MAX_NOTES))) begin
                     if (mode_ff != hna_pkg::MODE_OFF || out_free) begin
                        for (int i = 0; i < MAX_NOTES; i++) begin
                           ctl[i].wr = (CNT_W'(i) == count_ff);
                        end
                        count_in = count_ff + 1'b1;
                     end
                  end
                  if (mode_ff == hna_pkg::MODE_OFF) begin
                     if (found || count_ff == CNT_W'(MAX_NOTES)) begin
                        state_in = hna_pkg::ST_IDLE;
                     end else if (out_free) begin
                        emit      = 1'b1;
                        emit_ev   = hna_pkg::EV_ON;
                        emit_note = qnote_ff;
                        state_in  = hna_pkg::ST_IDLE;
                     end
                  end else if (!running_ff) begin
                     running_in  = 1'b0;
                     step_cnt_in = '0;
                     gate_cnt_in = '0;
                     state_in    = hna_pkg::ST_STEP;
                  end else begin
                     state_in = hna_pkg::ST_IDLE;
                  end
               end

               hna_pkg::OP_RELEASE: begin
                  if (mode_ff == hna_pkg::MODE_OFF) begin
                     if (!found) begin
                        state_in = hna_pkg::ST_IDLE;
                     end else if (out_free) begin
                        for (int i = 0; i < MAX_NOTES; i++) ctl[i].shift = shift_vec[i];
                        count_in  = count_ff - 1'b1;
                        emit      = 1'b1;
                        emit_ev   = hna_pkg::EV_OFF;
                        emit_note = qnote_ff;
                        state_in  = hna_pkg::ST_IDLE;
                     end
                  end else begin
                     for (int i = 0; i < MAX_NOTES; i++) ctl[i].shift = shift_vec[i];
                     count_in = count_ff - CNT_W'(found);
                     if ((count_ff - CNT_W'(found)) == '0 || !running_ff) begin
                        running_in  = 1'b0;
                        step_cnt_in = '0;
                        gate_cnt_in = '0;
                        state_in    = hna_pkg::ST_STEP;
                     end else begin
                        state_in = hna_pkg::ST_IDLE;
                     end
                  end
               end

               hna_pkg::OP_TICK: begin
                  if (!running_ff) begin
                     state_in = hna_pkg::ST_IDLE;
                  end else if (!goff || out_free) begin
                     // The gate is served before the step when both run out together.
                     if (gate_cnt_ff != '0) gate_cnt_in = gate_cnt_ff - 1'b1;
                     if (step_cnt_ff != '0) step_cnt_in = step_cnt_ff - 1'b1;
                     if (goff) begin
                        emit       = 1'b1;
                        emit_ev    = hna_pkg::EV_OFF;
                        emit_note  = snd_note_ff;
                        emit_last  = !(fire && more_on);
                        snd_vld_in = 1'b0;
                     end
                     state_in = fire ? hna_pkg::ST_STEP : hna_pkg::ST_IDLE;
                  end
               end

               default: begin
                  running_in  = 1'b0;
                  step_cnt_in = '0;
                  gate_cnt_in = '0;
                  state_in    = hna_pkg::ST_ALLOFF;
               end
            endcase
         end

         hna_pkg::ST_STEP: begin
            if (!snd_vld_ff || out_free) begin
               if (snd_vld_ff) begin
                  emit       = 1'b1;
                  emit_ev    = hna_pkg::EV_OFF;
                  emit_note  = snd_note_ff;
                  emit_last  = !more_on;
                  snd_vld_in = 1'b0;
               end
               if (!more_on) begin
                  running_in  = 1'b0;
                  step_cnt_in = '0;
                  gate_cnt_in = '0;
                  state_in    = hna_pkg::ST_IDLE;
               end else begin
                  div_start   = 1'b1;
                  div_divisor = hna_pkg::DVS_W'(count_ff);
                  case (mode_ff)
                     hna_pkg::MODE_UP: div_dividend = 32'(pos_up);
                     hna_pkg::MODE_DOWN: begin
                        if (pos_ff[POS_W-1] || pos_ff == '0) begin
                           div_dividend = 32'(count_ff - 1'b1);
                        end else begin
                           div_dividend = 32'(pos_dn);
                        end
                     end
                     default: begin
                        rnd_in       = x3;
                        div_dividend = x3;
                     end
                  endcase
                  for (int i = 0; i < MAX_NOTES; i++) ctl[i].load = 1'b1;
                  rot_cnt_in = CNT_W'(MAX_NOTES);
                  state_in   = hna_pkg::ST_DIVPOS;
               end
            end
         end

         hna_pkg::ST_DIVPOS: begin
            if (rot_cnt_ff != '0) begin
               for (int i = 0; i < MAX_NOTES; i++) ctl[i].rot = 1'b1;
               rot_cnt_in = rot_cnt_ff - 1'b1;
            end
            if (div_done) begin
               pos_in   = POS_W'(div_rem);
               state_in = hna_pkg::ST_PICK;
            end
         end

         hna_pkg::ST_PICK: begin
            snd_note_in = sel_note;
            prod_in     = hna_pkg::PROD_W'(st_eff) * hna_pkg::PROD_W'(gp_eff);
            state_in    = hna_pkg::ST_GSTART;
         end

         hna_pkg::ST_GSTART: begin
            gate_q_in = gate_mul[hna_pkg::RECIP_SH +: SW];
            state_in  = hna_pkg::ST_DIVGATE;
         end

         hna_pkg::ST_DIVGATE: begin
            gate_cnt_in = gate_len;
            state_in    = hna_pkg::ST_ON;
         end

         hna_pkg::ST_ON: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_ev     = hna_pkg::EV_ON;
               emit_note   = snd_note_ff;
               snd_vld_in  = 1'b1;
               step_cnt_in = st_eff;
               running_in  = 1'b1;
               state_in    = hna_pkg::ST_IDLE;
            end
         end

         hna_pkg::ST_ALLOFF: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_last = 1'b0;
               if (mode_ff != hna_pkg::MODE_OFF && snd_vld_ff) begin
                  emit_ev    = hna_pkg::EV_OFF;
                  emit_note  = snd_note_ff;
                  snd_vld_in = 1'b0;
               end else if (mode_ff == hna_pkg::MODE_OFF && count_ff != '0) begin
                  // Cell zero holds the oldest note; the row moves down behind it.
                  emit_ev   = hna_pkg::EV_OFF;
                  emit_note = cell_note[0];
                  for (int i = 0; i < MAX_NOTES; i++) ctl[i].shift = 1'b1;
                  count_in  = count_ff - 1'b1;
               end else begin
                  emit_ev   = hna_pkg::EV_ALL;
                  emit_last = 1'b1;
                  count_in  = '0;
                  state_in  = hna_pkg::ST_IDLE;
               end
            end
         end

         default: state_in = hna_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_note_in  = rsp_note_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_ev_in    = emit_ev;
         rsp_note_in  = emit_note;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hna_pkg::ST_IDLE;
         count_ff     <= '0;
         pos_ff       <= '1;
         snd_vld_ff   <= 1'b0;
         step_cnt_ff  <= '0;
         gate_cnt_ff  <= '0;
         running_ff   <= 1'b0;
         rnd_ff       <= hna_pkg::RANDOM_RST;
         rot_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         snd_vld_ff   <= snd_vld_in;
         step_cnt_ff  <= step_cnt_in;
         gate_cnt_ff  <= gate_cnt_in;
         running_ff   <= running_in;
         rnd_ff       <= rnd_in;
         rot_cnt_ff   <= rot_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      qnote_ff    <= qnote_in;
      snd_note_ff <= snd_note_in;
      prod_ff     <= prod_in;
      gate_q_ff   <= gate_q_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_note_ff <= rsp_note_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_note_ff};
   assign rsp_tuser  = rsp_ev_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### hw/rtl/hna_checker.sv
// Port-level checks of the arpeggiator, bound to the top level.
module hna_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // A held result beat keeps its contents until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
      && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // One request is worked on at a time.
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // The all-notes-off result always closes its run and names no note.
   a_all_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == hna_pkg::EV_ALL |-> rsp_tlast && rsp_tdata == 8'd0)
      else $error("all-notes-off beat malformed");

   // Only the three event codes are ever sent.
   a_ev_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == hna_pkg::EV_ON || rsp_tuser == hna_pkg::EV_OFF
      || rsp_tuser == hna_pkg::EV_ALL)
      else $error("unknown event code");

endmodule

bind held_note_arpeggiator_top hna_checker u_hna_checker (.*);
